### design/gbm_pkg.sv
`timescale 1ns / 1ps
package gbm_pkg;

  // Item and register widths
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int LEN_W      = 13;
  localparam int MAG_W      = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  // Fixed-point layout
  localparam int FRAC_W     = 16;
  localparam int STATE_W    = 56;
  localparam int MAX_BLOCK  = 4096;
  localparam int MIN_BLOCK  = 2;
  // full scale is 2^FS_SHIFT - 1
  localparam int FS_SHIFT   = 15;

  // Shared coefficient multiplier: state word split in two chunks
  localparam int CHUNK_W    = STATE_W / 2;
  localparam int MCOEF_W    = COEF_W + 1;
  localparam int MOP_W      = CHUNK_W + 1;
  localparam int PROD_W     = MCOEF_W + MOP_W;
  localparam int SUM_W      = PROD_W + CHUNK_W;
  localparam int T_W        = SUM_W - FRAC_W;
  localparam int RE_W       = T_W + 1;

  // Divider
  localparam int DIVISOR_W  = LEN_W + FS_SHIFT;
  localparam int DSH_W      = DIVISOR_W + MAG_W;
  localparam int QUO_W      = MAG_W + 1;
  localparam int REM_W      = T_W;
  localparam int DIV_STEPS  = QUO_W;

  // Square and root
  localparam int SQ_W       = 2 * MAG_W;
  localparam int ROOT_IN_W  = SQ_W + 1;
  localparam int ROOT_W     = ROOT_IN_W + 1;
  localparam int ROOT_STEPS = (ROOT_IN_W + 1) / 2;

  localparam int STEP_W = $clog2((DIV_STEPS > ROOT_STEPS) ? DIV_STEPS : ROOT_STEPS);

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [MAG_W-1:0]           mag_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic [LEN_W-1:0]           len_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_COSINE   = 2'd0,
    CFG_BIN_SINE     = 2'd1,
    CFG_BLOCK_LENGTH = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    COEF_TWO_COS = 2'd0,
    COEF_COS     = 2'd1,
    COEF_SIN     = 2'd2
  } coef_sel_e;

  typedef struct packed {
    logic      valid;
    cfg_idx_t  index;
    cfg_data_t data;
  } cfg_wr_t;

  typedef struct packed {
    logic      latch_x;
    logic      mul_lo;
    logic      mul_hi;
    coef_sel_e coef_sel;
    logic      sum;
    logic      upd;
    logic      load_re;
    logic      load_im;
    logic      div_step;
    logic      sq_a;
    logic      sq_b;
    logic      sqrt_load;
    logic      sqrt_step;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    logic block_done;
  } status_t;

endpackage

### design/gbm_sample_if.sv
`timescale 1ns / 1ps
interface gbm_sample_if;
  logic             valid;
  logic             ready;
  gbm_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

### design/gbm_mag_if.sv
`timescale 1ns / 1ps
interface gbm_mag_if;
  logic          valid;
  logic          ready;
  gbm_pkg::mag_t magnitude;

  modport source (output valid, output magnitude, input ready);
  modport sink (input valid, input magnitude, output ready);
endinterface

### design/gbm_cfg_if.sv
`timescale 1ns / 1ps
interface gbm_cfg_if;
  logic               valid;
  logic               ready;
  gbm_pkg::cfg_idx_t  index;
  gbm_pkg::cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### design/gbm_datapath.sv
`timescale 1ns / 1ps
module gbm_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gbm_pkg::cfg_wr_t cfg_i,
  input  gbm_pkg::cmd_t    cmd_i,
  input  gbm_pkg::sample_t sample_i,
  output gbm_pkg::status_t status_o,
  output gbm_pkg::mag_t    magnitude_o
);
  import gbm_pkg::*;

  coef_t cos_q, sin_q;
  len_t  len_q;

  logic signed [STATE_W-1:0] q1_q, q1_d, q2_q, q2_d;
  len_t                      cnt_q, cnt_d;
  sample_t                   x_q;

  logic signed [PROD_W-1:0] plo_q, phi_q, mprod;
  logic signed [MCOEF_W-1:0] mcoef;
  logic signed [MOP_W-1:0]   mop;
  logic [STATE_W-1:0]        mop_src;
  logic [SUM_W-1:0]          csum;
  logic signed [T_W-1:0]     t_q;
  logic [STATE_W-1:0]        q0;

  logic signed [RE_W-1:0] q1_x, t_x, re_p, re_n, t_n, re_abs, im_abs, dvd;
  len_t                   n_eff;
  logic [LEN_W:0]         cnt_inc;
  logic [DIVISOR_W-1:0]   divisor;

  logic [REM_W-1:0] rem_q, dsh_ext;
  logic [DSH_W-1:0] dsh_q;
  logic [QUO_W-1:0] quot_q;
  logic             ge;

  logic [MAG_W-1:0]     a_q, sq_op;
  logic                 sat_q;
  logic [SQ_W-1:0]      sq1_q, sq2_q, sq_p;
  logic [ROOT_IN_W-1:0] v_q, bit_q;
  logic [ROOT_W-1:0]    r_q, rb;
  logic                 r_ge;
  mag_t                 mag_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= coef_t'(1 <<< FRAC_W);
      sin_q <= '0;
      len_q <= len_t'(256);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_BIN_COSINE:   cos_q <= coef_t'(cfg_i.data[COEF_W-1:0]);
        CFG_BIN_SINE:     sin_q <= coef_t'(cfg_i.data[COEF_W-1:0]);
        CFG_BLOCK_LENGTH: len_q <= cfg_i.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (len_q < len_t'(MIN_BLOCK)) begin
      n_eff = len_t'(MIN_BLOCK);
    end else if (len_q > len_t'(MAX_BLOCK)) begin
      n_eff = len_t'(MAX_BLOCK);
    end else begin
      n_eff = len_q;
    end
  end

  assign divisor = (DIVISOR_W'(n_eff) << FS_SHIFT) - DIVISOR_W'(n_eff);
  assign cnt_inc = {1'b0, cnt_q} + (LEN_W + 1)'(1);
  assign status_o.block_done = cnt_inc >= {1'b0, n_eff};

  // shared coefficient multiplier, one state chunk per cycle
  always_comb begin
    unique case (cmd_i.coef_sel)
      COEF_TWO_COS: mcoef = {cos_q, 1'b0};
      COEF_COS:     mcoef = {cos_q[COEF_W-1], cos_q};
      COEF_SIN:     mcoef = {sin_q[COEF_W-1], sin_q};
      default:      mcoef = '0;
    endcase
  end

  assign mop_src = (cmd_i.coef_sel == COEF_TWO_COS) ? q1_q : q2_q;
  assign mop = cmd_i.mul_hi ? {mop_src[STATE_W-1], mop_src[STATE_W-1:CHUNK_W]}
                            : {1'b0, mop_src[CHUNK_W-1:0]};
  assign mprod = mcoef * mop;

  assign csum = {{CHUNK_W{plo_q[PROD_W-1]}}, plo_q} + {phi_q, {CHUNK_W{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_x) x_q <= sample_i;
    if (cmd_i.mul_lo) plo_q <= mprod;
    if (cmd_i.mul_hi) phi_q <= mprod;
    if (cmd_i.sum) t_q <= csum[SUM_W-1:FRAC_W];
  end

  // resonator update, wraps at the state width
  assign q0 = t_q[STATE_W-1:0] - q2_q
            + {{(STATE_W-SAMPLE_W-FRAC_W){x_q[SAMPLE_W-1]}}, x_q, {FRAC_W{1'b0}}};

  always_comb begin
    q1_d  = q1_q;
    q2_d  = q2_q;
    cnt_d = cnt_q;
    if (cmd_i.upd) begin
      q2_d  = q1_q;
      q1_d  = q0;
      cnt_d = status_o.block_done ? '0 : cnt_inc[LEN_W-1:0];
    end else if (cmd_i.load_out) begin
      q1_d = '0;
      q2_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_q  <= '0;
      q2_q  <= '0;
      cnt_q <= '0;
    end else begin
      q1_q  <= q1_d;
      q2_q  <= q2_d;
      cnt_q <= cnt_d;
    end
  end

  // real and imaginary parts, magnitude only
  assign q1_x   = {{(RE_W-STATE_W){q1_q[STATE_W-1]}}, q1_q};
  assign t_x    = {t_q[T_W-1], t_q};
  assign re_p   = q1_x - t_x;
  assign re_n   = t_x - q1_x;
  assign t_n    = -t_x;
  assign re_abs = re_p[RE_W-1] ? re_n : re_p;
  assign im_abs = t_x[RE_W-1] ? t_n : t_x;
  assign dvd    = cmd_i.load_re ? re_abs : im_abs;

  // restoring divider, quotient MSB flags saturation
  assign dsh_ext = REM_W'(dsh_q);
  assign ge      = rem_q >= dsh_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_re || cmd_i.load_im) begin
      rem_q  <= {dvd[REM_W-2:0], 1'b0};
      dsh_q  <= {divisor, {MAG_W{1'b0}}};
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      if (ge) rem_q <= rem_q - dsh_ext;
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[QUO_W-2:0], ge};
    end
    if (cmd_i.load_im) begin
      a_q   <= quot_q[MAG_W-1:0];
      sat_q <= quot_q[MAG_W];
    end else if (cmd_i.sq_a) begin
      sat_q <= sat_q | quot_q[MAG_W];
    end
  end

  // squares and bitwise root
  assign sq_op = cmd_i.sq_a ? a_q : quot_q[MAG_W-1:0];
  assign sq_p  = sq_op * sq_op;
  assign rb    = r_q + ROOT_W'(bit_q);
  assign r_ge  = ROOT_W'(v_q) >= rb;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_a) sq1_q <= sq_p;
    if (cmd_i.sq_b) sq2_q <= sq_p;
    if (cmd_i.sqrt_load) begin
      v_q   <= {1'b0, sq1_q} + {1'b0, sq2_q};
      r_q   <= '0;
      bit_q <= ROOT_IN_W'(1) << (ROOT_IN_W - 1);
    end else if (cmd_i.sqrt_step) begin
      if (r_ge) begin
        v_q <= v_q - rb[ROOT_IN_W-1:0];
        r_q <= (r_q >> 1) + ROOT_W'(bit_q);
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.load_out) begin
      if (sat_q || (r_q > ROOT_W'(MAG_MAX))) begin
        mag_q <= MAG_MAX;
      end else begin
        mag_q <= r_q[MAG_W-1:0];
      end
    end
  end

  assign magnitude_o = mag_q;

endmodule

### design/gbm_controller.sv
`timescale 1ns / 1ps
module gbm_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  gbm_pkg::status_t status_i,
  output gbm_pkg::cmd_t    cmd_o
);
  import gbm_pkg::*;

  typedef enum logic [18:0] {
    ST_IDLE   = 19'h00001,
    ST_R_HI   = 19'h00002,
    ST_R_SUM  = 19'h00004,
    ST_R_UPD  = 19'h00008,
    ST_M_CLO  = 19'h00010,
    ST_M_CHI  = 19'h00020,
    ST_M_CSUM = 19'h00040,
    ST_M_RE   = 19'h00080,
    ST_DIV_A  = 19'h00100,
    ST_M_SLO  = 19'h00200,
    ST_M_SHI  = 19'h00400,
    ST_M_SSUM = 19'h00800,
    ST_M_IM   = 19'h01000,
    ST_DIV_B  = 19'h02000,
    ST_SQ_A   = 19'h04000,
    ST_SQ_B   = 19'h08000,
    ST_SQ_SUM = 19'h10000,
    ST_SQRT   = 19'h20000,
    ST_FIN    = 19'h40000
  } state_e;

  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);

  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                out_valid_q, out_valid_d;
  cmd_t                cmd;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.latch_x = 1'b1;
          cmd.mul_lo  = 1'b1;
          state_d     = ST_R_HI;
        end
      end
      ST_R_HI: begin
        cmd.mul_hi = 1'b1;
        state_d    = ST_R_SUM;
      end
      ST_R_SUM: begin
        cmd.sum = 1'b1;
        state_d = ST_R_UPD;
      end
      ST_R_UPD: begin
        cmd.upd = 1'b1;
        state_d = status_i.block_done ? ST_M_CLO : ST_IDLE;
      end
      ST_M_CLO: begin
        cmd.coef_sel = COEF_COS;
        cmd.mul_lo   = 1'b1;
        state_d      = ST_M_CHI;
      end
      ST_M_CHI: begin
        cmd.coef_sel = COEF_COS;
        cmd.mul_hi   = 1'b1;
        state_d      = ST_M_CSUM;
      end
      ST_M_CSUM: begin
        cmd.sum = 1'b1;
        state_d = ST_M_RE;
      end
      ST_M_RE: begin
        cmd.load_re = 1'b1;
        step_d      = DIV_LAST;
        state_d     = ST_DIV_A;
      end
      ST_DIV_A: begin
        cmd.div_step = 1'b1;
        step_d       = step_q - STEP_W'(1);
        if (step_q == '0) state_d = ST_M_SLO;
      end
      ST_M_SLO: begin
        cmd.coef_sel = COEF_SIN;
        cmd.mul_lo   = 1'b1;
        state_d      = ST_M_SHI;
      end
      ST_M_SHI: begin
        cmd.coef_sel = COEF_SIN;
        cmd.mul_hi   = 1'b1;
        state_d      = ST_M_SSUM;
      end
      ST_M_SSUM: begin
        cmd.sum = 1'b1;
        state_d = ST_M_IM;
      end
      ST_M_IM: begin
        cmd.load_im = 1'b1;
        step_d      = DIV_LAST;
        state_d     = ST_DIV_B;
      end
      ST_DIV_B: begin
        cmd.div_step = 1'b1;
        step_d       = step_q - STEP_W'(1);
        if (step_q == '0) state_d = ST_SQ_A;
      end
      ST_SQ_A: begin
        cmd.sq_a = 1'b1;
        state_d  = ST_SQ_B;
      end
      ST_SQ_B: begin
        cmd.sq_b = 1'b1;
        state_d  = ST_SQ_SUM;
      end
      ST_SQ_SUM: begin
        cmd.sqrt_load = 1'b1;
        step_d        = ROOT_LAST;
        state_d       = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_d        = step_q - STEP_W'(1);
        if (step_q == '0) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd.load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

### design/goertzel_bin_magnitude_unit.sv
`timescale 1ns / 1ps
// Channel      Dir  Payload                        Notes
// sample_i     in   sample    s16                  one resonator update per item
// cfg_i        in   index 2b, data 18b             0 cos, 1 sin, 2 block length
// magnitude_o  out  magnitude u18 (Q2.16)          one item per block
//
// A sample passes through accept, then high half product, sum, state update on
// the shared 19x29 coefficient multiplier. The last sample of a block adds
// two 19-step restoring divides and a 19-step bitwise square root.
// The result sits in an output register; new samples are taken while it waits,
// and only the next block end stalls on it. Reset clears the resonator state and
// loads the register defaults; config is always ready.
module goertzel_bin_magnitude_unit (
  input logic       clk_i,
  input logic       rst_ni,
  gbm_sample_if.sink sample_i,
  gbm_cfg_if.sink    cfg_i,
  gbm_mag_if.source  magnitude_o
);
  import gbm_pkg::*;

  cfg_wr_t cfg_wr;
  cmd_t    cmd;
  status_t status;

  assign cfg_i.ready   = 1'b1;
  assign cfg_wr.valid  = cfg_i.valid;
  assign cfg_wr.index  = cfg_i.index;
  assign cfg_wr.data   = cfg_i.data;

  gbm_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (magnitude_o.valid),
    .out_ready_i (magnitude_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gbm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .cmd_i       (cmd),
    .sample_i    (sample_i.sample),
    .status_o    (status),
    .magnitude_o (magnitude_o.magnitude)
  );

endmodule

### tb/sv/goertzel_bin_magnitude_unit_test.sv
`timescale 1ns / 1ps
module goertzel_bin_magnitude_unit_test;
  import gbm_pkg::*;

  localparam int SETTLE_CYCLES      = 100;
  localparam int RANDOM_SAMPLES     = 1550;
  localparam int HOLD_CYCLES        = 400;
  localparam int LONG_BLOCK_SAMPLES = 240;
  localparam int LONG_PHASE         = 6;
  localparam int PRESSURE_PHASE     = 3;
  localparam cfg_idx_t CFG_SPARE_INDEX = 2'd3;

  typedef logic signed [95:0] wide_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gbm_sample_if sample_ch();
  gbm_cfg_if    cfg_ch();
  gbm_mag_if    mag_ch();

  goertzel_bin_magnitude_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_ch),
    .cfg_i       (cfg_ch),
    .magnitude_o (mag_ch)
  );

  class bin_magnitude_tracker;
    coef_t                     cos_q;
    coef_t                     sin_q;
    len_t                      blen;
    logic signed [STATE_W-1:0] q1;
    logic signed [STATE_W-1:0] q2;
    len_t                      count;
    mag_t                      pending[$];
    int unsigned               mismatches;
    int unsigned               results_seen;
    int unsigned               saturated;

    function new();
      cos_q = 18'sd65536;
      sin_q = '0;
      blen = 13'd256;
      q1 = '0;
      q2 = '0;
      count = '0;
      mismatches = 0;
      results_seen = 0;
      saturated = 0;
    endfunction

    // floor(c * q / 2^FRAC_W)
    function wide_t coef_product(wide_t c, wide_t q);
      return (c * q) >>> FRAC_W;
    endfunction

    function longint unsigned integer_root(longint unsigned v);
      longint unsigned r;
      longint unsigned probe;
      r = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
        if (v >= r + probe) begin
          v = v - (r + probe);
          r = (r >> 1) + probe;
        end else begin
          r = r >> 1;
        end
        probe = probe >> 2;
      end
      return r;
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t d);
      case (idx)
        CFG_BIN_COSINE:   cos_q = d;
        CFG_BIN_SINE:     sin_q = d;
        CFG_BLOCK_LENGTH: blen = d[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function mag_t block_magnitude(int unsigned n);
      wide_t re;
      wide_t im;
      wide_t a;
      wide_t b;
      wide_t scale;
      longint unsigned root;
      re = wide_t'(q1) - coef_product(wide_t'(cos_q), wide_t'(q2));
      im = coef_product(wide_t'(sin_q), wide_t'(q2));
      a = (re < 0) ? -re : re;
      b = (im < 0) ? -im : im;
      scale = wide_t'(n) * ((1 << FS_SHIFT) - 1);
      a = (2 * a) / scale;
      b = (2 * b) / scale;
      if (a >= (wide_t'(4) <<< FRAC_W) || b >= (wide_t'(4) <<< FRAC_W)) begin
        saturated++;
        return MAG_MAX;
      end
      root = integer_root(64'(a * a + b * b));
      if (root > MAG_MAX) begin
        saturated++;
        return MAG_MAX;
      end
      return mag_t'(root);
    endfunction

    function void note_sample(sample_t s);
      wide_t q0;
      int unsigned n;
      mag_t expected_mag;
      q0 = coef_product(wide_t'(cos_q) <<< 1, wide_t'(q1)) - wide_t'(q2)
           + (wide_t'(s) <<< FRAC_W);
      q2 = q1;
      q1 = q0[STATE_W-1:0];
      count = count + 1'b1;
      n = blen;
      if (n < MIN_BLOCK) n = MIN_BLOCK;
      if (n > MAX_BLOCK) n = MAX_BLOCK;
      if (count >= n) begin
        expected_mag = block_magnitude(n);
        pending = {pending, expected_mag};
        q1 = '0;
        q2 = '0;
        count = '0;
      end
    endfunction

    function void check_magnitude(mag_t got);
      mag_t want;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: magnitude mismatch, expected none, got %0d", $time, got);
        return;
      end
      want = pending.pop_front();
      results_seen++;
      if (got !== want) begin
        mismatches++;
        $display("%0t: magnitude mismatch, expected %0d, got %0d", $time, want, got);
      end
    endfunction

    function void close_out();
      if (pending.size() != 0) begin
        mismatches += pending.size();
        $display("%0t: %0d magnitude(s) never arrived", $time, pending.size());
      end
    endfunction
  endclass

  bin_magnitude_tracker tracker = new();

  int        sender_idle_pct = 0;
  int        receiver_stall_pct = 0;
  int        holds_requested = 0;
  int        samples_sent = 0;
  int        regs_written = 0;
  int        phases_run = 0;
  sample_t   sample_plan[$];
  cfg_idx_t  reg_idx_q[$];
  cfg_data_t reg_val_q[$];

  always #1 clk_i = ~clk_i;

  initial begin : magnitude_receiver
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    mag_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mag_ch.valid && mag_ch.ready) tracker.check_magnitude(mag_ch.magnitude);
      if (hold_left == 0 && holds_done != holds_requested) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        mag_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        mag_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return sample_t'(int'($urandom_range(16)) - 8);
      3: return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic cfg_data_t pick_coef();
    int v;
    case ($urandom_range(9))
      0: v = 65536;
      1: v = -65536;
      2: v = 131071;
      3: v = -131072;
      4: v = 0;
      5, 6: v = $urandom;
      default: v = int'($urandom_range(131072)) - 65536;
    endcase
    return cfg_data_t'(v);
  endfunction

  function automatic cfg_data_t pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 55) return cfg_data_t'($urandom_range(12, 2));
    else if (r < 80) return cfg_data_t'($urandom_range(64, 13));
    else if (r < 90) return cfg_data_t'($urandom_range(1));
    else return cfg_data_t'($urandom_range(300, 65));
  endfunction

  task automatic queue_reg(cfg_idx_t idx, cfg_data_t v);
    reg_idx_q = {reg_idx_q, idx};
    reg_val_q = {reg_val_q, v};
  endtask

  task automatic flush_regs();
    while (reg_idx_q.size() != 0) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= reg_idx_q[0];
      cfg_ch.data <= reg_val_q[0];
      do @(posedge clk_i); while (!cfg_ch.ready);
      tracker.write_reg(reg_idx_q.pop_front(), reg_val_q.pop_front());
      regs_written++;
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic plan_random(int n);
    repeat (n) sample_plan = {sample_plan, pick_sample()};
  endtask

  task automatic send_plan();
    sample_t s;
    while (sample_plan.size() != 0) begin
      while ($urandom_range(99) < sender_idle_pct) begin
        sample_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
      s = sample_plan.pop_front();
      sample_ch.valid <= 1'b1;
      sample_ch.sample <= s;
      do @(posedge clk_i); while (!sample_ch.ready);
      tracker.note_sample(s);
      samples_sent++;
    end
    sample_ch.valid <= 1'b0;
  endtask

  // block may still be finishing a magnitude after the last item was taken
  task automatic settle();
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int ordinary_samples;
    ordinary_samples = 0;
    sample_ch.valid <= 1'b0;
    sample_ch.sample <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset coefficients, block left part-filled
    sample_plan = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001};
    send_plan();
    settle();

    // shortened below the current count: next item closes the block
    queue_reg(CFG_BLOCK_LENGTH, 18'd0);
    flush_regs();
    sample_plan = '{-16'sd1, 16'sh7FFF, 16'sh7FFF};
    send_plan();
    settle();

    // unstable resonator, saturating output
    queue_reg(CFG_BIN_COSINE, 18'h1FFFF);
    queue_reg(CFG_BIN_SINE, 18'h20000);
    queue_reg(CFG_BLOCK_LENGTH, 18'd4);
    flush_regs();
    sample_plan = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
    send_plan();
    settle();

    queue_reg(CFG_BIN_COSINE, 18'h20000);
    queue_reg(CFG_BIN_SINE, 18'h1FFFF);
    queue_reg(CFG_BLOCK_LENGTH, 18'd1);
    flush_regs();
    sample_plan = '{16'sh8000, 16'sh8000, 16'sh8000};
    send_plan();
    settle();

    queue_reg(CFG_BIN_COSINE, 18'd0);
    queue_reg(CFG_BIN_SINE, 18'd65536);
    queue_reg(CFG_BLOCK_LENGTH, 18'd8);
    queue_reg(CFG_SPARE_INDEX, cfg_data_t'($urandom));
    flush_regs();
    sample_plan = '{16'sd1, -16'sd1, 16'sd100};
    send_plan();
    settle();

    queue_reg(CFG_BLOCK_LENGTH, 18'd2);
    queue_reg(CFG_BIN_COSINE, cfg_data_t'(-65536));
    queue_reg(CFG_BIN_SINE, cfg_data_t'(-65536));
    flush_regs();
    sample_plan = '{16'sh7FFF, 16'sh8000, 16'sd12345, -16'sd4321};
    send_plan();
    settle();

    while (ordinary_samples < RANDOM_SAMPLES) begin
      case (phases_run % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
        default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
      endcase
      if (phases_run == LONG_PHASE) begin
        // all-ones length clamped down; a later shorter length closes the block
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        queue_reg(CFG_BLOCK_LENGTH, 18'h1FFF);
        queue_reg(CFG_BIN_COSINE, cfg_data_t'(int'($urandom_range(131072)) - 65536));
        queue_reg(CFG_BIN_SINE, cfg_data_t'(int'($urandom_range(131072)) - 65536));
        flush_regs();
        plan_random(LONG_BLOCK_SAMPLES);
        ordinary_samples += LONG_BLOCK_SAMPLES;
      end else if (phases_run == PRESSURE_PHASE) begin
        // receiver holds off while short blocks keep coming
        sender_idle_pct = 0;
        queue_reg(CFG_BLOCK_LENGTH, 18'd2);
        flush_regs();
        holds_requested++;
        plan_random(60);
        ordinary_samples += 60;
      end else begin
        if ($urandom_range(99) < 70) queue_reg(CFG_BIN_COSINE, pick_coef());
        if ($urandom_range(99) < 70) queue_reg(CFG_BIN_SINE, pick_coef());
        if ($urandom_range(99) < 70) queue_reg(CFG_BLOCK_LENGTH, pick_length());
        if ($urandom_range(99) < 5) queue_reg(CFG_SPARE_INDEX, cfg_data_t'($urandom));
        flush_regs();
        plan_random($urandom_range(80, 10));
        ordinary_samples += sample_plan.size();
      end
      send_plan();
      settle();
      phases_run++;
    end

    settle();
    tracker.close_out();
    $display("Covered %0d samples and %0d magnitudes (%0d saturating) in %0d phases,",
             samples_sent, tracker.results_seen, tracker.saturated, phases_run);
    $display("%0d register writes incl. clamped lengths and one long output hold-off",
             regs_written);
    if (tracker.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
